>>> rtl/cosp_pkg.sv
// Shared constants for the co-occurrence synapse predictor.
package cosp_pkg;

    localparam int NSYN_DEF       = 64;
    localparam int CONNS_DEF      = 8;
    localparam int DEST_BITS_DEF  = 64;
    localparam int COUNT_BITS_DEF = 16;

    // Fixed field widths
    localparam int FUNC_W   = 2;
    localparam int VEC_W    = 64;
    localparam int SYNIDX_W = 6;
    localparam int CONNIDX_W = 3;
    localparam int DEST_W   = 6;

    // Prediction ratio: count * PRED_MUL >= total * PRED_THR
    localparam int PRED_MUL = 10;
    localparam int PRED_THR = 7 + 1;

    typedef enum logic [FUNC_W-1:0] {
        FN_LOAD    = 2'd0,
        FN_LEARN   = 2'd1,
        FN_PREDICT = 2'd2,
        FN_NOP     = 2'd3
    } func_t;

endpackage

>>> rtl/cosp_conn_mem.sv
// Connection memory: destination id and hit count per connection.
module cosp_conn_mem
    import cosp_pkg::*;
#(
    parameter int DEPTH      = NSYN_DEF * CONNS_DEF,
    parameter int AW         = 9,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         we,
    input  logic [AW-1:0]                waddr,
    input  logic [DEST_W+COUNT_BITS-1:0] wdata,
    input  logic                         re,
    input  logic [AW-1:0]                raddr,
    output logic [DEST_W+COUNT_BITS-1:0] rdata
);

    logic [DEST_W+COUNT_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/cosp_tot_mem.sv
// Synapse total memory: one saturating total per synapse.
module cosp_tot_mem
    import cosp_pkg::*;
#(
    parameter int DEPTH      = NSYN_DEF,
    parameter int SW         = 6,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  we,
    input  logic [SW-1:0]         waddr,
    input  logic [COUNT_BITS-1:0] wdata,
    input  logic                  re,
    input  logic [SW-1:0]         raddr,
    output logic [COUNT_BITS-1:0] rdata
);

    logic [COUNT_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/cooccurrence_synapse_predictor.sv
// Top level of the co-occurrence synapse predictor: sequencer and datapath.
//
// An item is taken at a clock edge where start is high and busy is low; its
// single result appears on predicted_bits for exactly one cycle with done high,
// and the receiver cannot stall it, so it must take it in that cycle.
// Learn and predict walk every connection of every synapse through the
// connection memory, one entry per cycle on its separate read and write
// ports, then pass a drain state before the result is registered. Load,
// and the unused func code, pass the load state before the result is
// registered. After reset the block runs a clearing pass over every entry
// that restores the reset contents of both memories; busy stays high during
// it. busy is low in the cycle that carries done, so a new item may follow
// right behind a result. predicted_bits is zero for everything but predict.
module cooccurrence_synapse_predictor
    import cosp_pkg::*;
#(
    parameter int NSYN       = NSYN_DEF,
    parameter int CONNS      = CONNS_DEF,
    parameter int DEST_BITS  = DEST_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [FUNC_W-1:0]    func,
    input  logic [VEC_W-1:0]     src_bits,
    input  logic [VEC_W-1:0]     dst_bits,
    input  logic [SYNIDX_W-1:0]  syn_index,
    input  logic [CONNIDX_W-1:0] conn_index,
    input  logic [DEST_W-1:0]    dest_id,
    output logic                 done,
    output logic [VEC_W-1:0]     predicted_bits
);

    localparam int NENT = NSYN * CONNS;
    localparam int AW   = (NENT  > 1) ? $clog2(NENT)  : 1;
    localparam int SW   = (NSYN  > 1) ? $clog2(NSYN)  : 1;
    localparam int CW   = (CONNS > 1) ? $clog2(CONNS) : 1;
    localparam int DW   = DEST_W + COUNT_BITS;
    localparam int CMPW = COUNT_BITS + 4;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_WALK  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_LOAD  = 5'b10000
    } state_t;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        sat_inc = (&v) ? v : v + COUNT_BITS'(1);
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t               state_reg, state_next;
    logic [AW-1:0]        fe_reg, fe_next;       // fetch entry
    logic [SW-1:0]        fs_reg, fs_next;       // fetch synapse
    logic [CW-1:0]        fj_reg, fj_next;       // fetch connection
    logic                 pv_reg, pv_next;       // process stage valid
    logic [AW-1:0]        pe_reg;
    logic [SW-1:0]        ps_reg;
    logic [CW-1:0]        pj_reg;
    logic                 hit_reg, hit_next;     // any match in current synapse
    logic [VEC_W-1:0]     pred_reg, pred_next;
    logic                 done_reg, done_next;
    logic [VEC_W-1:0]     out_reg, out_next;

    // latched item
    func_t                func_reg;
    logic [VEC_W-1:0]     src_reg;
    logic [VEC_W-1:0]     dst_reg;
    logic                 ld_ok_reg;
    logic [AW-1:0]        ld_addr_reg;
    logic [SW-1:0]        ld_syn_reg;
    logic [DEST_W-1:0]    ld_dest_reg;

    // ------------------------------------------------------------------
    // Memory ports
    // ------------------------------------------------------------------
    logic                  cm_we, cm_re;
    logic [AW-1:0]         cm_waddr;
    logic [DW-1:0]         cm_wdata, cm_rdata;
    logic                  tm_we, tm_re;
    logic [SW-1:0]         tm_waddr;
    logic [COUNT_BITS-1:0] tm_wdata, tm_rdata;

    cosp_conn_mem #(
        .DEPTH      (NENT),
        .AW         (AW),
        .COUNT_BITS (COUNT_BITS)
    ) u_conn_mem (
        .clk   (clk),
        .we    (cm_we),
        .waddr (cm_waddr),
        .wdata (cm_wdata),
        .re    (cm_re),
        .raddr (fe_reg),
        .rdata (cm_rdata)
    );

    cosp_tot_mem #(
        .DEPTH      (NSYN),
        .SW         (SW),
        .COUNT_BITS (COUNT_BITS)
    ) u_tot_mem (
        .clk   (clk),
        .we    (tm_we),
        .waddr (tm_waddr),
        .wdata (tm_wdata),
        .re    (tm_re),
        .raddr (fs_reg),
        .rdata (tm_rdata)
    );

    // ------------------------------------------------------------------
    // Process stage: entry read last cycle is evaluated here
    // ------------------------------------------------------------------
    logic [DEST_W-1:0]     p_dest;
    logic [COUNT_BITS-1:0] p_count;
    logic                  p_active;
    logic                  p_dest_ok;
    logic                  p_match;
    logic                  p_hit;
    logic                  p_last_conn;
    logic                  p_ratio_ok;
    logic [CMPW-1:0]       p_lhs, p_rhs;

    assign p_dest      = cm_rdata[DW-1:COUNT_BITS];
    assign p_count     = cm_rdata[COUNT_BITS-1:0];
    assign p_active    = src_reg[ps_reg];
    assign p_dest_ok   = ({1'b0, p_dest} < 7'(DEST_BITS));
    assign p_match     = p_active && p_dest_ok && dst_reg[p_dest];
    assign p_hit       = ((pj_reg == '0) ? 1'b0 : hit_reg) | p_match;
    assign p_last_conn = (pj_reg == CW'(CONNS - 1));
    // 10*count >= 8*total, computed as constant multiplies
    assign p_lhs       = CMPW'(p_count)  * CMPW'(PRED_MUL);
    assign p_rhs       = CMPW'(tm_rdata) * CMPW'(PRED_THR);
    assign p_ratio_ok  = (p_lhs >= p_rhs);

    logic fetch_last;
    logic fetch_on;
    logic accept;

    assign fetch_last = (fe_reg == AW'(NENT - 1));
    assign fetch_on   = (state_reg == ST_CLEAR) || (state_reg == ST_WALK);
    assign accept     = start && (state_reg == ST_IDLE);
    assign busy       = (state_reg != ST_IDLE);

    // memory read enables; total is read once at the head of each synapse
    assign cm_re = (state_reg == ST_WALK);
    assign tm_re = (state_reg == ST_WALK) && (fj_reg == '0);

    // memory write muxes
    always_comb
    begin
        cm_we    = 1'b0;
        cm_waddr = pe_reg;
        cm_wdata = {p_dest, sat_inc(p_count)};
        tm_we    = 1'b0;
        tm_waddr = ps_reg;
        tm_wdata = sat_inc(tm_rdata);
        case (state_reg)
            ST_CLEAR:
            begin
                // connection j watches bit j, counts and totals zero
                cm_we    = 1'b1;
                cm_waddr = fe_reg;
                cm_wdata = {DEST_W'(fj_reg), {COUNT_BITS{1'b0}}};
                tm_we    = (fj_reg == '0);
                tm_waddr = fs_reg;
                tm_wdata = '0;
            end
            ST_LOAD:
            begin
                cm_we    = ld_ok_reg;
                cm_waddr = ld_addr_reg;
                cm_wdata = {ld_dest_reg, {COUNT_BITS{1'b0}}};
                tm_we    = ld_ok_reg;
                tm_waddr = ld_syn_reg;
                tm_wdata = '0;
            end
            default:
            begin
                if (pv_reg && (func_reg == FN_LEARN))
                begin
                    cm_we = p_match;
                    tm_we = p_last_conn && p_hit;
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        fe_next    = fe_reg;
        fs_next    = fs_reg;
        fj_next    = fj_reg;
        pv_next    = 1'b0;
        hit_next   = hit_reg;
        pred_next  = pred_reg;
        done_next  = 1'b0;
        out_next   = out_reg;

        if (fetch_on)
        begin
            if (fetch_last)
            begin
                fe_next = '0;
                fs_next = '0;
                fj_next = '0;
            end
            else
            begin
                fe_next = fe_reg + AW'(1);
                if (fj_reg == CW'(CONNS - 1))
                begin
                    fj_next = '0;
                    fs_next = fs_reg + SW'(1);
                end
                else
                begin
                    fj_next = fj_reg + CW'(1);
                end
            end
        end

        if (pv_reg)
        begin
            hit_next = p_hit;
            if (p_active && (tm_rdata != '0) && p_ratio_ok && p_dest_ok)
            begin
                pred_next = pred_reg | (VEC_W'(1) << p_dest);
            end
        end

        case (state_reg)
            ST_CLEAR:
            begin
                if (fetch_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    pred_next = '0;
                    if (func == FN_LEARN || func == FN_PREDICT)
                    begin
                        state_next = ST_WALK;
                    end
                    else
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_WALK:
            begin
                pv_next = 1'b1;
                if (fetch_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last entry is in the process stage
                done_next  = 1'b1;
                out_next   = (func_reg == FN_PREDICT) ? pred_next : '0;
                state_next = ST_IDLE;
            end
            ST_LOAD:
            begin
                done_next  = 1'b1;
                out_next   = '0;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            fe_reg    <= '0;
            fs_reg    <= '0;
            fj_reg    <= '0;
            pv_reg    <= 1'b0;
            hit_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fe_reg    <= fe_next;
            fs_reg    <= fs_next;
            fj_reg    <= fj_next;
            pv_reg    <= pv_next;
            hit_reg   <= hit_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pred_reg <= pred_next;
        out_reg  <= out_next;
        pe_reg   <= fe_reg;
        ps_reg   <= fs_reg;
        pj_reg   <= fj_reg;
        if (accept)
        begin
            func_reg    <= func_t'(func);
            src_reg     <= src_bits;
            dst_reg     <= dst_bits;
            // unused func code also passes through ST_LOAD but writes nothing
            ld_ok_reg   <= (func == FN_LOAD) &&
                           ({1'b0, syn_index} < 7'(NSYN)) &&
                           ({4'b0, conn_index} < 7'(CONNS));
            ld_addr_reg <= AW'(32'(syn_index) * CONNS + 32'(conn_index));
            ld_syn_reg  <= SW'(syn_index);
            ld_dest_reg <= dest_id;
        end
    end

    assign done           = done_reg;
    assign predicted_bits = out_reg;

endmodule

>>> sim/tb_cooccurrence_synapse_predictor.sv
`timescale 1ns / 100ps
// Self-checking testbench for the co-occurrence synapse predictor.
module tb_cooccurrence_synapse_predictor;
    import cosp_pkg::*;

    localparam int NSYN       = NSYN_DEF;
    localparam int CONNS      = CONNS_DEF;
    localparam int DEST_BITS  = DEST_BITS_DEF;
    localparam int COUNT_BITS = COUNT_BITS_DEF;
    localparam int NENT       = NSYN * CONNS;

    // A connection fires when count * CNT_WEIGHT >= total * TOT_WEIGHT.
    localparam longint CNT_WEIGHT = 10;
    localparam longint TOT_WEIGHT = 8;
    localparam longint CNT_MAX    = (64'd1 << COUNT_BITS) - 1;

    // Random part of the run, in items; the directed part comes on top.
    localparam int RANDOM_ITEMS = 1150;
    // Cycles without any transfer or result before the run is declared hung.
    // Worst correct gap: the clearing pass after reset plus one full walk
    // plus a short sender gap.
    localparam int QUIET_LIMIT  = 6000;
    // Settle time after the last result: one full walk and some margin.
    localparam int DRAIN_CYCLES = NENT + 16;

    typedef struct {
        func_t               fn;
        logic [VEC_W-1:0]    src;
        logic [VEC_W-1:0]    dst;
        logic [SYNIDX_W-1:0] syn;
        logic [CONNIDX_W-1:0] conn;
        logic [DEST_W-1:0]   dest;
    } synapse_cmd_t;

    // Shadow copy of the synapse array. Load and learn commands update it;
    // every accepted command queues the destination vector the block must answer with.
    class synapse_shadow;
        logic [DEST_W-1:0] conn_dest [NENT];
        longint            conn_count [NENT];
        longint            syn_total [NSYN];
        logic [VEC_W-1:0]  pending_predictions [$];
        int                errors;

        function new();
            errors = 0;
            for (int e = 0; e < NENT; e++) begin
                conn_dest[e]  = DEST_W'((e % CONNS) % 64);
                conn_count[e] = 0;
            end
            for (int s = 0; s < NSYN; s++)
                syn_total[s] = 0;
        endfunction

        function longint bump(longint v);
            return (v >= CNT_MAX) ? v : v + 1;
        endfunction

        function void note_command(synapse_cmd_t c);
            logic [VEC_W-1:0] guess;
            bit               hit;
            int               e;
            guess = '0;
            case (c.fn)
                FN_LOAD:
                begin
                    // Rewire one slot; its count and the synapse total restart.
                    if (c.syn < NSYN && c.conn < CONNS)
                    begin
                        e = int'(c.syn) * CONNS + int'(c.conn);
                        conn_dest[e]     = c.dest;
                        conn_count[e]    = 0;
                        syn_total[c.syn] = 0;
                    end
                end
                FN_LEARN:
                begin
                    for (int s = 0; s < NSYN && s < VEC_W; s++)
                    begin
                        if (c.src[s])
                        begin
                            hit = 0;
                            for (int j = 0; j < CONNS; j++)
                            begin
                                e = s * CONNS + j;
                                if (conn_dest[e] < DEST_BITS && c.dst[conn_dest[e]])
                                begin
                                    hit = 1;
                                    conn_count[e] = bump(conn_count[e]);
                                end
                            end
                            if (hit)
                                syn_total[s] = bump(syn_total[s]);
                        end
                    end
                end
                FN_PREDICT:
                begin
                    for (int s = 0; s < NSYN && s < VEC_W; s++)
                    begin
                        if (c.src[s] && syn_total[s] != 0)
                        begin
                            for (int j = 0; j < CONNS; j++)
                            begin
                                e = s * CONNS + j;
                                if (conn_count[e] * CNT_WEIGHT >= syn_total[s] * TOT_WEIGHT
                                    && conn_dest[e] < DEST_BITS)
                                    guess[conn_dest[e]] = 1'b1;
                            end
                        end
                    end
                end
                default:
                    ;
            endcase
            pending_predictions.push_back(guess);
        endfunction

        function void check_prediction(logic [VEC_W-1:0] got);
            logic [VEC_W-1:0] want;
            if (pending_predictions.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing outstanding: expected none actual %h",
                         $time, got);
            end
            else
            begin
                want = pending_predictions.pop_front();
                if (got !== want)
                begin
                    errors++;
                    $display("%0t: predicted_bits expected %h actual %h", $time, want, got);
                end
            end
        endfunction
    endclass

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 start      = 1'b0;
    logic [FUNC_W-1:0]    func       = '0;
    logic [VEC_W-1:0]     src_bits   = '0;
    logic [VEC_W-1:0]     dst_bits   = '0;
    logic [SYNIDX_W-1:0]  syn_index  = '0;
    logic [CONNIDX_W-1:0] conn_index = '0;
    logic [DEST_W-1:0]    dest_id    = '0;
    logic                 busy;
    logic                 done;
    logic [VEC_W-1:0]     predicted_bits;

    synapse_shadow shadow;
    synapse_cmd_t  stimulus [$];
    int            quiet_cycles = 0;

    cooccurrence_synapse_predictor dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .func           (func),
        .src_bits       (src_bits),
        .dst_bits       (dst_bits),
        .syn_index      (syn_index),
        .conn_index     (conn_index),
        .dest_id        (dest_id),
        .done           (done),
        .predicted_bits (predicted_bits)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Results cannot be held off, so every strobe is checked on the spot.
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            shadow.check_prediction(predicted_bits);
    end

    // Hang detector: restarts on any transfer or result.
    always @(posedge clk)
    begin
        if ((start && busy === 1'b0) || done === 1'b1)
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [VEC_W-1:0] rand_vec();
        return {$urandom, $urandom};
    endfunction

    // Vector with a random density: dense, medium, sparse or a single bit.
    function automatic logic [VEC_W-1:0] shaped_vec();
        case ($urandom_range(3))
            0: return rand_vec();
            1: return rand_vec() & rand_vec();
            2: return rand_vec() & rand_vec() & rand_vec();
            default: return 64'd1 << $urandom_range(63);
        endcase
    endfunction

    function automatic synapse_cmd_t mk(func_t fn, logic [VEC_W-1:0] src,
                                        logic [VEC_W-1:0] dst, int syn, int conn,
                                        int dest);
        synapse_cmd_t c;
        c.fn   = fn;
        c.src  = src;
        c.dst  = dst;
        c.syn  = SYNIDX_W'(syn);
        c.conn = CONNIDX_W'(conn);
        c.dest = DEST_W'(dest);
        return c;
    endfunction

    function automatic synapse_cmd_t noise_cmd();
        return mk(func_t'($urandom_range(3)), rand_vec(), rand_vec(),
                  $urandom_range(63), $urandom_range(7), $urandom_range(63));
    endfunction

    task automatic build_directed();
        logic [VEC_W-1:0] ones;
        logic [VEC_W-1:0] syn1;
        ones = '1;
        syn1 = 64'd1 << 1;
        // Prediction from an untrained array is empty: every total is zero.
        stimulus.push_back(mk(FN_PREDICT, ones, ones, 0, 0, 0));
        // Full co-occurrence: every default connection hits once.
        stimulus.push_back(mk(FN_LEARN, ones, ones, 63, 7, 63));
        stimulus.push_back(mk(FN_PREDICT, ones, '0, 0, 0, 0));
        stimulus.push_back(mk(FN_NOP, ones, ones, 63, 7, 63));
        stimulus.push_back(mk(FN_LOAD, ones, ones, 63, 7, 63));
        stimulus.push_back(mk(FN_LOAD, '0, '0, 0, 0, 0));
        // Synapse 1 rewired; slots 1 and 2 watch the same bit.
        stimulus.push_back(mk(FN_LOAD, ones, '0, 1, 0, 40));
        stimulus.push_back(mk(FN_LOAD, '0, ones, 1, 1, 41));
        stimulus.push_back(mk(FN_LOAD, '0, '0, 1, 2, 41));
        // Four full hits and one partial: slot 0 ends exactly on the 4/5 ratio.
        repeat (4)
            stimulus.push_back(mk(FN_LEARN, syn1 | (64'd1 << 63),
                                  (64'd1 << 40) | (64'd1 << 41) | (64'd1 << 63), 0, 0, 0));
        stimulus.push_back(mk(FN_LEARN, syn1, 64'd1 << 41, 0, 0, 0));
        stimulus.push_back(mk(FN_PREDICT, syn1 | (64'd1 << 63), '0, 0, 0, 0));
        // One more partial hit drops slot 0 below the ratio.
        stimulus.push_back(mk(FN_LEARN, syn1, 64'd1 << 41, 0, 0, 0));
        stimulus.push_back(mk(FN_PREDICT, syn1, '0, 0, 0, 0));
        // Learn with no destination activity leaves everything alone.
        stimulus.push_back(mk(FN_LEARN, ones, '0, 0, 0, 0));
        stimulus.push_back(mk(FN_PREDICT, '0, ones, 0, 0, 0));
        stimulus.push_back(mk(FN_PREDICT, ones, ones, 63, 7, 63));
        stimulus.push_back(mk(FN_NOP, '0, '0, 0, 0, 0));
    endtask

    // Episodes: rewire a few slots, train on a noisy pattern, then ask for it
    // back. Part of the traffic is unstructured noise.
    task automatic build_random();
        int               added;
        logic [VEC_W-1:0] pat_src;
        logic [VEC_W-1:0] pat_dst;
        added = 0;
        while (added < RANDOM_ITEMS)
        begin
            if ($urandom_range(99) < 15)
            begin
                stimulus.push_back(noise_cmd());
                added++;
            end
            else
            begin
                pat_src = shaped_vec();
                pat_dst = shaped_vec();
                repeat ($urandom_range(3))
                begin
                    stimulus.push_back(mk(FN_LOAD, rand_vec(), rand_vec(),
                                          $urandom_range(63), $urandom_range(7),
                                          $urandom_range(63)));
                    added++;
                end
                repeat ($urandom_range(6, 2))
                begin
                    stimulus.push_back(mk(FN_LEARN, pat_src,
                                          pat_dst ^ (rand_vec() & rand_vec() & rand_vec()),
                                          $urandom_range(63), $urandom_range(7),
                                          $urandom_range(63)));
                    added++;
                end
                repeat ($urandom_range(2, 1))
                begin
                    stimulus.push_back(mk(FN_PREDICT,
                                          ($urandom_range(3) == 0) ? shaped_vec() : pat_src,
                                          rand_vec(), $urandom_range(63),
                                          $urandom_range(7), $urandom_range(63)));
                    added++;
                end
            end
        end
    endtask

    // Holds the command on the bus until it is taken. start drops at random
    // in any cycle, busy or not, so gaps land on every phase of a walk.
    task automatic send_command(synapse_cmd_t c, int idle_pct);
        bit taken;
        taken = 0;
        while (!taken)
        begin
            if ($urandom_range(99) < idle_pct)
                start <= 1'b0;
            else
            begin
                start      <= 1'b1;
                func       <= c.fn;
                src_bits   <= c.src;
                dst_bits   <= c.dst;
                syn_index  <= c.syn;
                conn_index <= c.conn;
                dest_id    <= c.dest;
            end
            @(posedge clk);
            if (start && !busy)
            begin
                taken = 1;
                shadow.note_command(c);
            end
        end
    endtask

    initial
    begin
        // Sender idle percentage per quarter of the run. The receiver side has
        // no stall, so its phase runs without idling.
        int idle_pct [4];
        int total;
        idle_pct = '{0, 56, 0, 37};
        shadow = new();
        build_directed();
        build_random();
        total = stimulus.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < total; i++)
            send_command(stimulus[i], idle_pct[(i * 4) / total]);
        start <= 1'b0;

        while (shadow.pending_predictions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (shadow.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/cosp_pkg.sv
rtl/cosp_conn_mem.sv
rtl/cosp_tot_mem.sv
rtl/cooccurrence_synapse_predictor.sv
sim/tb_cooccurrence_synapse_predictor.sv
